FILE: rtl/core/nmea_sentence_framer_macros.svh
// Assertion macros shared by the sentence framer checkers.
// No dependencies; include by bare file name.
`ifndef NMEA_SENTENCE_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sentence framer assertion failed");

// Next-cycle implication, disabled during reset.
`define NSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sentence framer assertion failed");

`endif

FILE: rtl/core/nsf_pkg.sv
// Shared types, constants and helper functions for the NMEA sentence framer.
// No dependencies.
package nsf_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } nsf_action_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SENTENCE_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NO_DATA_TIMEOUT  = 1'd1;
    localparam logic [31:0] SENTENCE_TIMEOUT_RESET = 32'd1000000;
    localparam logic [31:0] NO_DATA_TIMEOUT_RESET  = 32'd2000000;

    localparam logic [7:0] LINE_CHARS = 8'd128;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Address length saturates here; only "five or more" matters
    localparam logic [2:0] ADDR_LEN_MIN = 3'd5;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_RMC   = 3'd1;
    localparam logic [2:0] KIND_GGA   = 3'd2;
    localparam logic [2:0] KIND_VTG   = 3'd3;
    localparam logic [2:0] KIND_GSA   = 3'd4;
    localparam logic [2:0] KIND_ZDA   = 3'd5;

    localparam logic [23:0] TAG_RMC = 24'h524D43;
    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_VTG = 24'h565447;
    localparam logic [23:0] TAG_GSA = 24'h475341;
    localparam logic [23:0] TAG_ZDA = 24'h5A4441;

    // Counter indexes, window set follows the total set
    localparam int NUM_COUNTERS = 5;
    localparam logic [2:0] CNT_BYTES      = 3'd0;
    localparam logic [2:0] CNT_SENTENCES  = 3'd1;
    localparam logic [2:0] CNT_BAD_SUM    = 3'd2;
    localparam logic [2:0] CNT_OVERLONG   = 3'd3;
    localparam logic [2:0] CNT_UNFINISHED = 3'd4;
    localparam logic [3:0] SEL_WINDOW_BASE = 4'd5;
    localparam logic [3:0] SEL_LIMIT       = 4'd10;

    typedef struct packed {
        logic       done;
        logic       ok;
        logic [2:0] kind;
        logic [7:0] len;
    } nsf_frame_t;

    typedef struct packed {
        logic byte_rx;
        logic sentence;
        logic bad_sum;
        logic overlong;
        logic unfinished;
    } nsf_events_t;

    // Returns {invalid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b0, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b0, 4'(c - 8'h57)};
        else
            r = 5'h10;
        return r;
    endfunction

    function automatic logic [2:0] kind_of(input logic [23:0] tail, input logic [2:0] alen);
        logic [2:0] k;
        if (alen != ADDR_LEN_MIN)
            k = KIND_OTHER;
        else if (tail == TAG_RMC)
            k = KIND_RMC;
        else if (tail == TAG_GGA)
            k = KIND_GGA;
        else if (tail == TAG_VTG)
            k = KIND_VTG;
        else if (tail == TAG_GSA)
            k = KIND_GSA;
        else if (tail == TAG_ZDA)
            k = KIND_ZDA;
        else
            k = KIND_OTHER;
        return k;
    endfunction

endpackage

FILE: rtl/core/nsf_in_if.sv
// Input channel of the sentence framer: valid/ready plus one input item.
// No dependencies.
interface nsf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [31:0] time_us;
    logic [3:0] counter_select;

    modport source (output valid, action, byte_value, time_us, counter_select, input ready);
    modport sink   (input valid, action, byte_value, time_us, counter_select, output ready);
endinterface

FILE: rtl/core/nsf_out_if.sv
// Result channel of the sentence framer: valid/ready plus one result item.
// No dependencies.
interface nsf_out_if;
    logic        valid;
    logic        ready;
    logic        sentence_done;
    logic        checksum_ok;
    logic [2:0]  sentence_kind;
    logic [7:0]  sentence_length;
    logic        receiving;
    logic [31:0] counter_value;

    modport source (output valid, sentence_done, checksum_ok, sentence_kind, sentence_length,
                    receiving, counter_value, input ready);
    modport sink   (input valid, sentence_done, checksum_ok, sentence_kind, sentence_length,
                    receiving, counter_value, output ready);
endinterface

FILE: rtl/core/nsf_parser.sv
// Sentence framing and checksum state, updated once per item.
// Depends on nsf_pkg.
module nsf_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  nsf_pkg::nsf_action_t action,
    input  logic [7:0]           byte_value,
    input  logic [31:0]          time_us,
    input  logic [31:0]          sentence_timeout,
    output nsf_pkg::nsf_frame_t  frame,
    output nsf_pkg::nsf_events_t events
);
    import nsf_pkg::*;

    logic        collecting_reg, collecting_next;
    logic        overlong_reg, overlong_next;
    logic [7:0]  line_len_reg, line_len_next;
    logic [31:0] start_reg, start_next;
    logic [7:0]  xor_reg, xor_next;
    logic        star_reg, star_next;
    logic [1:0]  digits_reg, digits_next;
    logic [7:0]  given_reg, given_next;
    logic        hex_ok_reg, hex_ok_next;
    logic [23:0] tail_reg, tail_next;
    logic [2:0]  alen_reg, alen_next;
    logic        adone_reg, adone_next;
    logic [4:0]  hex;
    logic        is_eol;

    assign hex    = hex_digit(byte_value);
    assign is_eol = (byte_value == CH_CR) || (byte_value == CH_LF);

    always_comb
    begin
        collecting_next = collecting_reg;
        overlong_next   = overlong_reg;
        line_len_next   = line_len_reg;
        start_next      = start_reg;
        xor_next        = xor_reg;
        star_next       = star_reg;
        digits_next     = digits_reg;
        given_next      = given_reg;
        hex_ok_next     = hex_ok_reg;
        tail_next       = tail_reg;
        alen_next       = alen_reg;
        adone_next      = adone_reg;
        frame           = '0;
        events          = '0;
        if (step)
        begin
            unique case (action)
                ACT_BYTE:
                begin
                    events.byte_rx = 1'b1;
                    if (byte_value == CH_DOLLAR)
                    begin
                        // A new dollar drops any open sentence silently
                        collecting_next = 1'b1;
                        overlong_next   = 1'b0;
                        line_len_next   = 8'd1;
                        start_next      = time_us;
                        xor_next        = '0;
                        star_next       = 1'b0;
                        digits_next     = '0;
                        given_next      = '0;
                        hex_ok_next     = 1'b1;
                        tail_next       = '0;
                        alen_next       = '0;
                        adone_next      = 1'b0;
                    end
                    else if (collecting_reg)
                    begin
                        if (is_eol)
                        begin
                            collecting_next = 1'b0;
                            if (overlong_reg)
                                events.overlong = 1'b1;
                            else
                            begin
                                frame.done = 1'b1;
                                frame.len  = line_len_reg;
                                frame.kind = kind_of(tail_reg, alen_reg);
                                frame.ok   = star_reg && (digits_reg == 2'd2) && hex_ok_reg
                                             && (given_reg == xor_reg);
                                events.sentence = 1'b1;
                                events.bad_sum  = !frame.ok;
                            end
                        end
                        else if (line_len_reg >= LINE_CHARS)
                            overlong_next = 1'b1;
                        else
                        begin
                            line_len_next = line_len_reg + 8'd1;
                            if (!star_reg)
                            begin
                                if (byte_value == CH_STAR)
                                begin
                                    star_next  = 1'b1;
                                    adone_next = 1'b1;
                                end
                                else
                                begin
                                    xor_next = xor_reg ^ byte_value;
                                    if (!adone_reg)
                                    begin
                                        if (byte_value == CH_COMMA)
                                        begin
                                            // Leading commas are skipped
                                            if (alen_reg != 3'd0)
                                                adone_next = 1'b1;
                                        end
                                        else
                                        begin
                                            tail_next = {tail_reg[15:0], byte_value};
                                            if (alen_reg != ADDR_LEN_MIN)
                                                alen_next = alen_reg + 3'd1;
                                        end
                                    end
                                end
                            end
                            else if (digits_reg != 2'd2)
                            begin
                                if (hex[4])
                                    hex_ok_next = 1'b0;
                                else
                                    given_next = {given_reg[3:0], hex[3:0]};
                                digits_next = digits_reg + 2'd1;
                            end
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (collecting_reg && ((time_us - start_reg) > sentence_timeout))
                    begin
                        collecting_next   = 1'b0;
                        line_len_next     = '0;
                        events.unfinished = 1'b1;
                    end
                end
                ACT_READ:
                begin
                end
                ACT_CLEAR:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            overlong_reg   <= 1'b0;
            line_len_reg   <= '0;
            start_reg      <= '0;
            xor_reg        <= '0;
            star_reg       <= 1'b0;
            digits_reg     <= '0;
            given_reg      <= '0;
            hex_ok_reg     <= 1'b0;
            tail_reg       <= '0;
            alen_reg       <= '0;
            adone_reg      <= 1'b0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            overlong_reg   <= overlong_next;
            line_len_reg   <= line_len_next;
            start_reg      <= start_next;
            xor_reg        <= xor_next;
            star_reg       <= star_next;
            digits_reg     <= digits_next;
            given_reg      <= given_next;
            hex_ok_reg     <= hex_ok_next;
            tail_reg       <= tail_next;
            alen_reg       <= alen_next;
            adone_reg      <= adone_next;
        end
    end

endmodule

FILE: rtl/core/nsf_counters.sv
// Total and window event counters with read select and window clear.
// Depends on nsf_pkg.
module nsf_counters (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  nsf_pkg::nsf_action_t action,
    input  logic [3:0]           counter_select,
    input  nsf_pkg::nsf_events_t events,
    output logic [31:0]          value
);
    import nsf_pkg::*;

    logic [31:0] total_reg  [NUM_COUNTERS];
    logic [31:0] total_next [NUM_COUNTERS];
    logic [31:0] window_reg  [NUM_COUNTERS];
    logic [31:0] window_next [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] bump;
    logic [3:0] win_sel;
    logic       clear;

    always_comb
    begin
        bump[CNT_BYTES]      = events.byte_rx;
        bump[CNT_SENTENCES]  = events.sentence;
        bump[CNT_BAD_SUM]    = events.bad_sum;
        bump[CNT_OVERLONG]   = events.overlong;
        bump[CNT_UNFINISHED] = events.unfinished;
    end

    assign clear = step && (action == ACT_CLEAR);

    always_comb
    begin
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            total_next[i]  = total_reg[i] + {31'd0, bump[i]};
            window_next[i] = clear ? 32'd0 : window_reg[i] + {31'd0, bump[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                total_reg[i]  <= '0;
                window_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                total_reg[i]  <= total_next[i];
                window_reg[i] <= window_next[i];
            end
        end
    end

    assign win_sel = counter_select - SEL_WINDOW_BASE;

    always_comb
    begin
        value = '0;
        if (action == ACT_READ)
        begin
            priority if (counter_select < SEL_WINDOW_BASE)
                value = total_reg[counter_select[2:0]];
            else if (counter_select < SEL_LIMIT)
                value = window_reg[win_sel[2:0]];
            else
                value = '0;
        end
    end

endmodule

FILE: rtl/core/nsf_rx_monitor.sv
// Tracks the time of the last good sentence and derives the receiving flag.
// No package dependency.
module nsf_rx_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        good,
    input  logic [31:0] time_us,
    input  logic [31:0] no_data_timeout,
    output logic        receiving
);
    logic        have_reg, have_next;
    logic [31:0] last_end_reg, last_end_next;

    assign have_next     = (step && good) ? 1'b1 : have_reg;
    assign last_end_next = (step && good) ? time_us : last_end_reg;

    // A good sentence in this item gives an age of zero
    assign receiving = good ? (no_data_timeout != 32'd0)
                            : (have_reg && ((time_us - last_end_reg) < no_data_timeout));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            last_end_reg <= '0;
        end
        else
        begin
            have_reg     <= have_next;
            last_end_reg <= last_end_next;
        end
    end

endmodule

FILE: rtl/core/nmea_sentence_framer.sv
// NMEA sentence framer: an accepted item passes an input register and then a result
// register, from which it leaves once the result is taken. Sustained rate is one
// item per cycle while results are taken. A stalled result holds the input register:
// it takes one more item while empty, then ready drops.
// Reset (rst_n, async low) clears framing state, counters, pipeline valids and
// restores the timeout registers to their defaults.
module nmea_sentence_framer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_wdata,
    nsf_in_if.sink                            feed,
    nsf_out_if.source                         report
);
    import nsf_pkg::*;

    logic [31:0] sent_timeout_reg, nodata_timeout_reg;

    logic        s1_valid_reg;
    nsf_action_t s1_action_reg;
    logic [7:0]  s1_byte_reg;
    logic [31:0] s1_time_reg;
    logic [3:0]  s1_sel_reg;

    logic        out_valid_reg;
    nsf_frame_t  out_frame_reg;
    logic        out_rx_reg;
    logic [31:0] out_value_reg;

    logic        advance, step;
    nsf_frame_t  frame;
    nsf_events_t events;
    logic        receiving;
    logic [31:0] cnt_value;

    assign advance    = !out_valid_reg || report.ready;
    assign step       = s1_valid_reg && advance;
    assign feed.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_timeout_reg   <= SENTENCE_TIMEOUT_RESET;
            nodata_timeout_reg <= NO_DATA_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SENTENCE_TIMEOUT: sent_timeout_reg   <= cfg_wdata;
                REG_NO_DATA_TIMEOUT:  nodata_timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (feed.ready)
                s1_valid_reg <= feed.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed.valid && feed.ready)
        begin
            s1_action_reg <= nsf_action_t'(feed.action);
            s1_byte_reg   <= feed.byte_value;
            s1_time_reg   <= feed.time_us;
            s1_sel_reg    <= feed.counter_select;
        end
        if (step)
        begin
            out_frame_reg <= frame;
            out_rx_reg    <= receiving;
            out_value_reg <= cnt_value;
        end
    end

    nsf_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .action           (s1_action_reg),
        .byte_value       (s1_byte_reg),
        .time_us          (s1_time_reg),
        .sentence_timeout (sent_timeout_reg),
        .frame            (frame),
        .events           (events)
    );

    nsf_counters u_counters (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .action         (s1_action_reg),
        .counter_select (s1_sel_reg),
        .events         (events),
        .value          (cnt_value)
    );

    nsf_rx_monitor u_rx_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .good            (frame.done && frame.ok),
        .time_us         (s1_time_reg),
        .no_data_timeout (nodata_timeout_reg),
        .receiving       (receiving)
    );

    assign report.valid           = out_valid_reg;
    assign report.sentence_done   = out_frame_reg.done;
    assign report.checksum_ok     = out_frame_reg.ok;
    assign report.sentence_kind   = out_frame_reg.kind;
    assign report.sentence_length = out_frame_reg.len;
    assign report.receiving       = out_rx_reg;
    assign report.counter_value   = out_value_reg;

endmodule

FILE: rtl/core/nsf_checker.sv
// Port-level checks for the sentence framer, bound to the top level.
// Depends on nsf_pkg and nmea_sentence_framer_macros.svh.
`include "nmea_sentence_framer_macros.svh"

module nsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        feed_ready,
    input logic        report_valid,
    input logic        report_ready,
    input logic        sentence_done,
    input logic        checksum_ok,
    input logic [2:0]  sentence_kind,
    input logic [7:0]  sentence_length,
    input logic        receiving,
    input logic [31:0] counter_value
);
    import nsf_pkg::*;

    // A stalled result holds
    `NSF_ASSERT_NEXT(a_hold, clk, rst_n, report_valid && !report_ready, report_valid && $stable(sentence_done) && $stable(checksum_ok) && $stable(sentence_kind) && $stable(sentence_length) && $stable(receiving) && $stable(counter_value))
    // An empty result register never blocks the input
    `NSF_ASSERT_IMPLY(a_no_block, clk, rst_n, !report_valid, feed_ready)
    // Sentence fields are zero unless a sentence completed
    `NSF_ASSERT_IMPLY(a_idle_fields, clk, rst_n, report_valid && !sentence_done, !checksum_ok && sentence_kind == KIND_OTHER && sentence_length == 8'd0)
    // A completed sentence holds at least the dollar and fits the line
    `NSF_ASSERT_IMPLY(a_len_range, clk, rst_n, report_valid && sentence_done, sentence_length != 8'd0 && sentence_length <= LINE_CHARS)

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .feed_ready      (feed.ready),
    .report_valid    (report.valid),
    .report_ready    (report.ready),
    .sentence_done   (report.sentence_done),
    .checksum_ok     (report.checksum_ok),
    .sentence_kind   (report.sentence_kind),
    .sentence_length (report.sentence_length),
    .receiving       (report.receiving),
    .counter_value   (report.counter_value)
);
